@@ sv/gmp_pkg.sv @@
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared types, widths, register codes and state encoding for the grid
// membership preflight block.
// ----------------------------------------------------------------------------
package gmp_pkg;

   // Width of the running total of cell memberships.
   localparam int TOTAL_BITS = 48;

   localparam int EDGE_W     = 64;  // box edge and cell index width
   localparam int CELL_W     = 32;  // per-box cell count and 32-bit registers
   localparam int LIMIT_W    = 48;  // max_total_cells register
   localparam int OUT_TOT_W  = 48;  // total_cells result field
   localparam int STATUS_W   = 3;

   // Total compare is done one bit wider than anything it sees.
   localparam int CMP_W = ((TOTAL_BITS > LIMIT_W) ? TOTAL_BITS : LIMIT_W) + 1;

   localparam int DIV_CNT_W = $clog2(EDGE_W);
   localparam int MUL_CNT_W = $clog2(CELL_W);

   localparam int EDGE_CNT = 4;
   localparam int EDGE_IDX_W = $clog2(EDGE_CNT);
   localparam logic [EDGE_IDX_W-1:0] LAST_EDGE = EDGE_IDX_W'(EDGE_CNT - 1);

   // Configuration port.
   localparam int DATA_W   = 64;
   localparam int ADDR_LSB = 3;
   localparam int ADDR_W   = ADDR_LSB + 2;

   localparam logic [CELL_W-1:0]  PITCH_RESET       = CELL_W'(128);
   localparam logic [CELL_W-1:0]  ENLARGEMENT_RESET = '0;
   localparam logic [CELL_W-1:0]  MAX_BOX_RESET     = CELL_W'(64);
   localparam logic [LIMIT_W-1:0] MAX_TOTAL_RESET   = LIMIT_W'(16000000);

   typedef enum logic [1:0] {
      REG_PITCH       = 2'd0,
      REG_ENLARGEMENT = 2'd1,
      REG_MAX_BOX     = 2'd2,
      REG_MAX_TOTAL   = 2'd3
   } reg_index_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_BOX     = 3'd1,
      STATUS_BOX_LIMIT   = 3'd2,
      STATUS_TOTAL_LIMIT = 3'd3,
      STATUS_BAD_CONFIG  = 3'd4
   } status_type;

   typedef struct packed {
      logic [CELL_W-1:0]  grid_pitch;
      logic [CELL_W-1:0]  enlargement;
      logic [CELL_W-1:0]  max_cells_per_box;
      logic [LIMIT_W-1:0] max_total_cells;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK_X,
      ST_CHECK_Y,
      ST_GROW,
      ST_DIV,
      ST_SPAN_X,
      ST_SPAN_Y,
      ST_LIMIT,
      ST_MUL,
      ST_PRODUCT,
      ST_TOTAL,
      ST_FINISH
   } state_type;

endpackage

@@ sv/gmp_req_if.sv @@
// ----------------------------------------------------------------------------
// gmp_req_if
// Input channel: one box with its last-of-run flag per word.
// ----------------------------------------------------------------------------
interface gmp_req_if import gmp_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [EDGE_W-1:0] box_left;
   logic signed [EDGE_W-1:0] box_bottom;
   logic signed [EDGE_W-1:0] box_right;
   logic signed [EDGE_W-1:0] box_top;
   logic                     last_box;

   modport source (
      output valid, box_left, box_bottom, box_right, box_top, last_box,
      input  ready
   );
   modport sink (
      input  valid, box_left, box_bottom, box_right, box_top, last_box,
      output ready
   );
endinterface

@@ sv/gmp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gmp_rsp_if
// Result channel: cell count, running total and status per word.
// ----------------------------------------------------------------------------
interface gmp_rsp_if import gmp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CELL_W-1:0]    box_cells;
   logic [OUT_TOT_W-1:0] total_cells;
   logic [STATUS_W-1:0]  fit_status;
   logic                 last_result;

   modport source (
      output valid, box_cells, total_cells, fit_status, last_result,
      input  ready
   );
   modport sink (
      input  valid, box_cells, total_cells, fit_status, last_result,
      output ready
   );
endinterface

@@ sv/gmp_csr.sv @@
// ----------------------------------------------------------------------------
// gmp_csr
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module gmp_csr import gmp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = reg_index_type'(paddr[ADDR_W-1:ADDR_LSB]);
   assign write_en = psel && penable && pwrite;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_PITCH:       cfg_in.grid_pitch        = pwdata[CELL_W-1:0];
            REG_ENLARGEMENT: cfg_in.enlargement       = pwdata[CELL_W-1:0];
            REG_MAX_BOX:     cfg_in.max_cells_per_box = pwdata[CELL_W-1:0];
            REG_MAX_TOTAL:   cfg_in.max_total_cells   = pwdata[LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PITCH:       prdata = DATA_W'(cfg_ff.grid_pitch);
         REG_ENLARGEMENT: prdata = DATA_W'(cfg_ff.enlargement);
         REG_MAX_BOX:     prdata = DATA_W'(cfg_ff.max_cells_per_box);
         REG_MAX_TOTAL:   prdata = DATA_W'(cfg_ff.max_total_cells);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_pitch        <= PITCH_RESET;
         cfg_ff.enlargement       <= ENLARGEMENT_RESET;
         cfg_ff.max_cells_per_box <= MAX_BOX_RESET;
         cfg_ff.max_total_cells   <= MAX_TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/gmp_divider.sv @@
// ----------------------------------------------------------------------------
// gmp_divider
// Bit-serial restoring divider: unsigned 64-bit dividend by a nonzero 32-bit
// divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gmp_divider import gmp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [EDGE_W-1:0] dividend,
   input  logic [CELL_W-1:0] divisor,
   output logic              done,
   output logic [EDGE_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CELL_W-1:0]    rem_ff, rem_in;
   logic [EDGE_W-1:0]    quo_ff, quo_in;
   logic [CELL_W-1:0]    dsr_ff, dsr_in;
   logic [CELL_W:0]      shifted;
   logic [CELL_W:0]      diff;
   logic                 fits;

   // The quotient register shifts out dividend bits at the top while the
   // quotient bits enter at the bottom.
   assign shifted = {rem_ff, quo_ff[EDGE_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[CELL_W-1:0] : shifted[CELL_W-1:0];
         quo_in = {quo_ff[EDGE_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(EDGE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

@@ sv/gmp_multiplier.sv @@
// ----------------------------------------------------------------------------
// gmp_multiplier
// Shift-add multiplier: 32 by 32 bits unsigned, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gmp_multiplier import gmp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [CELL_W-1:0]   mul_a,
   input  logic [CELL_W-1:0]   mul_b,
   output logic                done,
   output logic [2*CELL_W-1:0] product
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CELL_W-1:0]    a_ff, a_in;
   logic [CELL_W-1:0]    b_ff, b_in;
   logic [2*CELL_W-1:0]  acc_ff, acc_in;
   logic [CELL_W:0]      upper_sum;

   // Add into the upper half, then shift the whole accumulator right.
   assign upper_sum = {1'b0, acc_ff[2*CELL_W-1:CELL_W]} +
                      (a_ff[0] ? {1'b0, b_ff} : '0);

   assign done    = done_ff;
   assign product = acc_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = mul_a;
         b_in    = mul_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in = {upper_sum, acc_ff[CELL_W-1:1]};
         a_in   = a_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(CELL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

endmodule

@@ sv/grid_membership_preflight.sv @@
// ----------------------------------------------------------------------------
// grid_membership_preflight
// Bins boxes onto a uniform grid and checks cell counts against limits.
// ----------------------------------------------------------------------------
// Each input word is one box. The box is grown by the enlargement margin, its
// edges are floor-divided by the grid pitch on a single bit-serial
// divider, and the cell spans are multiplied on a bit-serial multiplier. One
// box is in work at a time: after the config and edge order are checked, each
// edge in turn is grown and divided; the spans are then checked against the
// box limit, multiplied, checked again and added to the running total under
// the total limit. A box that fails early, or arrives while a failure is
// sticky, skips the remaining steps. A finished result waits in an output
// register, so the next box is accepted while it is still pending. The
// status holds its first failure until the box marked last, whose result
// carries the values before the running total and status return to zero.
// ----------------------------------------------------------------------------
module grid_membership_preflight import gmp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   gmp_req_if.sink           req_ch,
   gmp_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type cfg;

   state_type state_ff, state_in;

   logic signed [EDGE_W-1:0] edge_ff [EDGE_CNT];
   logic signed [EDGE_W-1:0] edge_in [EDGE_CNT];
   logic [EDGE_W-1:0]        quo_ff  [EDGE_CNT];
   logic [EDGE_W-1:0]        quo_in  [EDGE_CNT];
   logic                     last_ff, last_in;
   logic [EDGE_IDX_W-1:0]    edge_idx_ff, edge_idx_in;
   logic                     neg_ff, neg_in;
   logic                     span_bad_ff, span_bad_in;
   logic [EDGE_W-1:0]        dx_ff, dx_in;
   logic [EDGE_W-1:0]        dy_ff, dy_in;
   logic [CELL_W-1:0]        cells_ff, cells_in;
   logic [TOTAL_BITS-1:0]    running_ff, running_in;
   status_type               sticky_ff, sticky_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]    rsp_cells_ff, rsp_cells_in;
   logic [OUT_TOT_W-1:0] rsp_total_ff, rsp_total_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                accept;
   logic                out_free;
   logic                cfg_bad;
   logic                x_inverted;
   logic                y_inverted;
   logic [EDGE_W:0]     grow_base;
   logic [EDGE_W:0]     grown;
   logic                grow_ovf;
   logic [EDGE_W-1:0]   grown_mag;
   logic [EDGE_W-1:0]   dx;
   logic [EDGE_W-1:0]   dy;
   logic [EDGE_W-1:0]   box_limit;
   logic                span_over;
   logic                product_over;
   logic [CMP_W-1:0]    run_ext;
   logic [CMP_W-1:0]    sum_ext;
   logic [CMP_W-1:0]    total_limit;
   logic                total_over;

   logic                div_start;
   logic                div_done;
   logic [EDGE_W-1:0]   div_quot;
   logic                mul_start;
   logic                mul_done;
   logic [2*CELL_W-1:0] mul_prod;
   logic [CELL_W-1:0]   mul_a;
   logic [CELL_W-1:0]   mul_b;

   gmp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gmp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (grown_mag),
      .divisor  (cfg.grid_pitch),
      .done     (div_done),
      .quotient (div_quot)
   );

   gmp_multiplier u_multiplier (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.box_cells   = rsp_cells_ff;
   assign rsp_ch.total_cells = rsp_total_ff;
   assign rsp_ch.fit_status  = rsp_status_ff;
   assign rsp_ch.last_result = rsp_last_ff;

   assign cfg_bad = (cfg.grid_pitch == '0) || (cfg.max_cells_per_box == '0) ||
                    (cfg.max_total_cells == '0);
   assign x_inverted = edge_ff[0] > edge_ff[1];
   assign y_inverted = edge_ff[2] > edge_ff[3];

   // Odd edge positions (right, top) grow upward, even ones downward. The
   // grown edge is kept one bit wider so that leaving the signed range shows.
   assign grow_base = {edge_ff[0][EDGE_W-1], edge_ff[0]};
   assign grown     = edge_idx_ff[0] ? grow_base + (EDGE_W+1)'(cfg.enlargement)
                                     : grow_base - (EDGE_W+1)'(cfg.enlargement);
   assign grow_ovf  = grown[EDGE_W] != grown[EDGE_W-1];

   // floor(v / d) for negative v equals the complement of (~v) / d, so the
   // divider only ever sees a nonnegative dividend.
   assign grown_mag = grown[EDGE_W-1] ? ~grown[EDGE_W-1:0] : grown[EDGE_W-1:0];

   assign dx        = quo_ff[1] - quo_ff[0];
   assign dy        = quo_ff[3] - quo_ff[2];
   assign box_limit = EDGE_W'(cfg.max_cells_per_box);

   // A span of dx cells' difference means dx + 1 cells, so dx >= limit is over.
   assign span_over    = (dx_ff >= box_limit) || (dy_ff >= box_limit);
   assign mul_a        = dx_ff[CELL_W-1:0] + 1'b1;
   assign mul_b        = dy_ff[CELL_W-1:0] + 1'b1;
   assign product_over = mul_prod > box_limit;

   assign run_ext     = CMP_W'(running_ff);
   assign sum_ext     = run_ext + CMP_W'(cells_ff);
   assign total_limit = CMP_W'(cfg.max_total_cells);
   assign total_over  = (run_ext > total_limit) || (sum_ext > total_limit);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (sticky_ff != STATUS_OK) ? ST_FINISH : ST_CHECK_X;
            end
         end
         ST_CHECK_X: begin
            state_in = (cfg_bad || x_inverted) ? ST_FINISH : ST_CHECK_Y;
         end
         ST_CHECK_Y: begin
            state_in = y_inverted ? ST_FINISH : ST_GROW;
         end
         ST_GROW: begin
            state_in = grow_ovf ? ST_FINISH : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = (edge_idx_ff == LAST_EDGE) ? ST_SPAN_X : ST_GROW;
            end
         end
         ST_SPAN_X: state_in = ST_SPAN_Y;
         ST_SPAN_Y: begin
            state_in = (span_bad_ff || (&dy)) ? ST_FINISH : ST_LIMIT;
         end
         ST_LIMIT: begin
            state_in = span_over ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_PRODUCT;
            end
         end
         ST_PRODUCT: begin
            state_in = product_over ? ST_FINISH : ST_TOTAL;
         end
         ST_TOTAL:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and unit controls.
   always_comb begin
      edge_in       = edge_ff;
      quo_in        = quo_ff;
      last_in       = last_ff;
      edge_idx_in   = edge_idx_ff;
      neg_in        = neg_ff;
      span_bad_in   = span_bad_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      cells_in      = cells_ff;
      running_in    = running_ff;
      sticky_in     = sticky_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_cells_in  = rsp_cells_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      mul_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               edge_in[0]  = req_ch.box_left;
               edge_in[1]  = req_ch.box_right;
               edge_in[2]  = req_ch.box_bottom;
               edge_in[3]  = req_ch.box_top;
               last_in     = req_ch.last_box;
               edge_idx_in = '0;
               cells_in    = '0;
            end
         end
         ST_CHECK_X: begin
            if (cfg_bad) begin
               sticky_in = STATUS_BAD_CONFIG;
            end else if (x_inverted) begin
               sticky_in = STATUS_BAD_BOX;
            end
         end
         ST_CHECK_Y: begin
            if (y_inverted) begin
               sticky_in = STATUS_BAD_BOX;
            end
         end
         ST_GROW: begin
            if (grow_ovf) begin
               sticky_in = STATUS_BAD_BOX;
            end else begin
               div_start = 1'b1;
               neg_in    = grown[EDGE_W-1];
               for (int i = 0; i < EDGE_CNT - 1; i++) begin
                  edge_in[i] = edge_ff[i+1];
               end
            end
         end
         ST_DIV: begin
            // Quotients enter at the top; after the last edge the order is
            // x0, x1, y0, y1 from the bottom.
            if (div_done) begin
               for (int i = 0; i < EDGE_CNT - 1; i++) begin
                  quo_in[i] = quo_ff[i+1];
               end
               quo_in[EDGE_CNT-1] = neg_ff ? ~div_quot : div_quot;
               edge_idx_in        = edge_idx_ff + 1'b1;
            end
         end
         ST_SPAN_X: begin
            dx_in       = dx;
            span_bad_in = &dx;
         end
         ST_SPAN_Y: begin
            dy_in = dy;
            if (span_bad_ff || (&dy)) begin
               sticky_in = STATUS_BAD_BOX;
            end
         end
         ST_LIMIT: begin
            if (span_over) begin
               sticky_in = STATUS_BOX_LIMIT;
            end else begin
               mul_start = 1'b1;
            end
         end
         ST_MUL: begin
         end
         ST_PRODUCT: begin
            if (product_over) begin
               sticky_in = STATUS_BOX_LIMIT;
            end else begin
               cells_in = mul_prod[CELL_W-1:0];
            end
         end
         ST_TOTAL: begin
            if (total_over) begin
               sticky_in = STATUS_TOTAL_LIMIT;
               cells_in  = '0;
            end else begin
               running_in = sum_ext[TOTAL_BITS-1:0];
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_cells_in  = cells_ff;
               rsp_total_in  = run_ext[OUT_TOT_W-1:0];
               rsp_status_in = sticky_ff;
               rsp_last_in   = last_ff;
               if (last_ff) begin
                  running_in = '0;
                  sticky_in  = STATUS_OK;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= '0;
         sticky_ff    <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      edge_ff       <= edge_in;
      quo_ff        <= quo_in;
      last_ff       <= last_in;
      edge_idx_ff   <= edge_idx_in;
      neg_ff        <= neg_in;
      span_bad_ff   <= span_bad_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      cells_ff      <= cells_in;
      rsp_cells_ff  <= rsp_cells_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

@@ sv/gmp_checker.sv @@
// ----------------------------------------------------------------------------
// gmp_checker
// Port-level checks for the grid membership preflight block, bound to the
// top level.
// ----------------------------------------------------------------------------
module gmp_checker import gmp_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [CELL_W-1:0]    rsp_box_cells,
   input logic [OUT_TOT_W-1:0] rsp_total_cells,
   input logic [STATUS_W-1:0]  rsp_fit_status,
   input logic                 rsp_last_result
);

   // Only one box is in work, so the input closes right after a word.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input stayed open after a word was accepted");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fit_status <= STATUS_BAD_CONFIG))
      else $error("result status outside the defined codes");

   // A failing or sticky result never reports cells.
   a_fail_no_cells: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_fit_status != STATUS_OK)) |-> (rsp_box_cells == '0))
      else $error("cells reported with a failure status");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_box_cells) && $stable(rsp_total_cells) &&
          $stable(rsp_fit_status) && $stable(rsp_last_result)))
      else $error("stalled result word changed");

endmodule

bind grid_membership_preflight gmp_checker u_gmp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_box_cells   (rsp_ch.box_cells),
   .rsp_total_cells (rsp_ch.total_cells),
   .rsp_fit_status  (rsp_ch.fit_status),
   .rsp_last_result (rsp_ch.last_result)
);

@@ tb/sv/tb_grid_membership_preflight.sv @@
// ----------------------------------------------------------------------------
// tb_grid_membership_preflight
// Self-checking testbench for the grid membership preflight block.
// ----------------------------------------------------------------------------
// Boxes are queued by the stimulus process and driven onto the request
// channel by a clocked driver. Each accepted box goes through a local model
// of the grid binning and limit checks, and the predicted word is queued for
// the response monitor. A directed set covers the corner cases first. After
// that, several register settings are swept with random runs of boxes, with
// random request gaps and response backpressure in all but the last group.
// ----------------------------------------------------------------------------
module tb_grid_membership_preflight;
   timeunit 1ns;
   timeprecision 1ps;
   import gmp_pkg::*;

   localparam logic [63:0]        SIGN64       = 64'h8000_0000_0000_0000;
   localparam logic signed [63:0] EDGE_MIN     = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] EDGE_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam int                 HOLD_CYCLES  = 3000;
   localparam int                 DRAIN_CYCLES = 400;

   typedef struct {
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] bottom;
      logic signed [EDGE_W-1:0] right;
      logic signed [EDGE_W-1:0] top;
      logic                     last_box;
   } box_word_type;

   typedef struct {
      logic [CELL_W-1:0]    box_cells;
      logic [OUT_TOT_W-1:0] total_cells;
      status_type           fit_status;
      logic                 last_result;
   } fit_word_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   gmp_req_if req_ch ();
   gmp_rsp_if rsp_ch ();

   grid_membership_preflight u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Model state: register copy, running total and sticky status.
   cfg_type                grid_cfg;
   logic [TOTAL_BITS-1:0]  run_total;
   status_type             run_status;

   box_word_type boxes_to_send[$];
   fit_word_type fits_expected[$];
   box_word_type box_on_bus;
   int           boxes_queued = 0;
   int           words_checked = 0;
   int           mismatches = 0;
   int           send_idle_pct = 32;
   int           recv_idle_pct = 81;
   logic         pressure_req = 1'b0;
   int unsigned  hold_left;
   logic         hold_done;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_grid_membership_preflight: FAIL");
      $finish;
   end

   // Floor division of a signed coordinate (given in offset binary) by the
   // grid pitch, returned as a two's complement cell index.
   function automatic logic [63:0] cell_index(input logic [63:0] grown,
                                              input logic [CELL_W-1:0] size);
      longint num;
      longint den;
      longint quo;
      num = grown ^ SIGN64;
      den = {32'd0, size};
      quo = num / den;
      if (num % den < 0)
         quo = quo - 1;
      return quo;
   endfunction

   function automatic status_type bin_box(input box_word_type b,
                                          output logic [63:0] cells);
      logic [63:0] xl, yl, xh, yh, grow, w, h, prod, limit, room, total;
      cells = '0;
      if (grid_cfg.grid_pitch == '0 || grid_cfg.max_cells_per_box == '0 ||
          grid_cfg.max_total_cells == '0)
         return STATUS_BAD_CONFIG;
      // Offset binary turns signed edge order into unsigned order.
      xl = b.left ^ SIGN64;
      yl = b.bottom ^ SIGN64;
      xh = b.right ^ SIGN64;
      yh = b.top ^ SIGN64;
      if (xl > xh || yl > yh)
         return STATUS_BAD_BOX;
      grow = 64'(grid_cfg.enlargement);
      if (xl < grow || yl < grow || xh > ~grow || yh > ~grow)
         return STATUS_BAD_BOX;
      w = cell_index(xh + grow, grid_cfg.grid_pitch)
          - cell_index(xl - grow, grid_cfg.grid_pitch) + 64'd1;
      h = cell_index(yh + grow, grid_cfg.grid_pitch)
          - cell_index(yl - grow, grid_cfg.grid_pitch) + 64'd1;
      // A span of 2^64 cells wraps the count around to zero.
      if (w == '0 || h == '0)
         return STATUS_BAD_BOX;
      limit = 64'(grid_cfg.max_cells_per_box);
      if (w > limit || h > limit)
         return STATUS_BOX_LIMIT;
      prod = w * h;
      if (prod > limit)
         return STATUS_BOX_LIMIT;
      room = 64'(grid_cfg.max_total_cells);
      total = 64'(run_total);
      if (total > room || prod > room - total)
         return STATUS_TOTAL_LIMIT;
      cells = prod;
      return STATUS_OK;
   endfunction

   function automatic fit_word_type predict_fit(input box_word_type b);
      fit_word_type f;
      logic [63:0]  cells;
      cells = '0;
      if (run_status == STATUS_OK) begin
         run_status = bin_box(b, cells);
         if (run_status == STATUS_OK)
            run_total = run_total + cells[TOTAL_BITS-1:0];
      end
      f.box_cells = cells[CELL_W-1:0];
      f.total_cells = OUT_TOT_W'(run_total);
      f.fit_status = run_status;
      f.last_result = b.last_box;
      if (b.last_box) begin
         run_total = '0;
         run_status = STATUS_OK;
      end
      return f;
   endfunction

   function automatic logic signed [63:0] extreme_edge();
      case ($urandom_range(5))
         0: return EDGE_MIN;
         1: return EDGE_MIN + $urandom_range(0, 300);
         2: return 64'sd0;
         3: return -64'sd1;
         4: return EDGE_MAX - $urandom_range(0, 300);
         default: return EDGE_MAX;
      endcase
   endfunction

   function automatic box_word_type random_box(input logic last);
      box_word_type       b;
      logic signed [63:0] swap;
      longint             pitch;
      longint             x_span;
      longint             y_span;
      int                 kind;
      kind = $urandom_range(99);
      pitch = (grid_cfg.grid_pitch == '0) ? 1 : grid_cfg.grid_pitch;
      b.left = $signed({$urandom, $urandom}) >>> 2;
      b.bottom = $signed({$urandom, $urandom}) >>> 2;
      b.last_box = last;
      x_span = pitch * $urandom_range(0, 7) + $urandom_range(0, pitch - 1);
      y_span = pitch * $urandom_range(0, 7) + $urandom_range(0, pitch - 1);
      if (kind >= 93) begin
         if ($urandom_range(1))
            x_span = pitch * $urandom_range(8, 300);
         else
            y_span = pitch * $urandom_range(8, 300);
      end
      b.right = b.left + x_span;
      b.top = b.bottom + y_span;
      if (kind >= 85 && kind < 93) begin
         if ($urandom_range(1))
            b.right = b.left - 1 - $urandom_range(0, 1000);
         else
            b.top = b.bottom - 1 - $urandom_range(0, 1000);
      end else if (kind >= 75 && kind < 85) begin
         b.left = extreme_edge();
         b.right = extreme_edge();
         b.bottom = extreme_edge();
         b.top = extreme_edge();
         if (b.left > b.right) begin
            swap = b.left;
            b.left = b.right;
            b.right = swap;
         end
         if (b.bottom > b.top) begin
            swap = b.bottom;
            b.bottom = b.top;
            b.top = swap;
         end
      end else if (kind >= 65 && kind < 75) begin
         b.left = {$urandom, $urandom};
         b.bottom = {$urandom, $urandom};
         b.right = {$urandom, $urandom};
         b.top = {$urandom, $urandom};
      end
      return b;
   endfunction

   task automatic queue_box(input box_word_type b);
      boxes_to_send.push_back(b);
      boxes_queued++;
   endtask

   // Every box yields exactly one word, so the block is idle once all
   // queued boxes have been answered.
   task automatic wait_idle();
      while (words_checked != boxes_queued)
         @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_reg(input reg_index_type idx, input logic [DATA_W-1:0] value);
      wait_idle();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(idx) << ADDR_LSB;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_PITCH:       grid_cfg.grid_pitch = value[CELL_W-1:0];
         REG_ENLARGEMENT: grid_cfg.enlargement = value[CELL_W-1:0];
         REG_MAX_BOX:     grid_cfg.max_cells_per_box = value[CELL_W-1:0];
         REG_MAX_TOTAL:   grid_cfg.max_total_cells = value[LIMIT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input logic [CELL_W-1:0] size, input logic [CELL_W-1:0] grow,
                            input logic [CELL_W-1:0] box_lim,
                            input logic [LIMIT_W-1:0] total_lim, input int count);
      int run_left;
      set_reg(REG_PITCH, size);
      set_reg(REG_ENLARGEMENT, grow);
      set_reg(REG_MAX_BOX, box_lim);
      set_reg(REG_MAX_TOTAL, total_lim);
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0)
            run_left = $urandom_range(1, 12);
         run_left--;
         queue_box(random_box(run_left == 0));
      end
   endtask

   task automatic log_miss(input string what);
      if (mismatches < 10)
         $display("%s", what);
      mismatches++;
   endtask

   // Request driver: holds a word until it is taken, then offers the next.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            fits_expected.push_back(predict_fit(box_on_bus));
         if (!req_ch.valid || req_ch.ready) begin
            if (boxes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               box_on_bus = boxes_to_send.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.box_left <= box_on_bus.left;
               req_ch.box_bottom <= box_on_bus.bottom;
               req_ch.box_right <= box_on_bus.right;
               req_ch.box_top <= box_on_bus.top;
               req_ch.last_box <= box_on_bus.last_box;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response ready, with one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_req && !hold_done) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      fit_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (fits_expected.size() == 0) begin
            log_miss($sformatf("unexpected word: cells %0d total %0d status %0d last %0d",
                               rsp_ch.box_cells, rsp_ch.total_cells, rsp_ch.fit_status,
                               rsp_ch.last_result));
         end else begin
            want = fits_expected.pop_front();
            if (rsp_ch.box_cells !== want.box_cells ||
                rsp_ch.total_cells !== want.total_cells ||
                rsp_ch.fit_status !== want.fit_status ||
                rsp_ch.last_result !== want.last_result)
               log_miss($sformatf({"word %0d: expected cells %0d total %0d status %0d ",
                                   "last %0d, got cells %0d total %0d status %0d last %0d"},
                                  words_checked, want.box_cells, want.total_cells,
                                  want.fit_status, want.last_result, rsp_ch.box_cells,
                                  rsp_ch.total_cells, rsp_ch.fit_status,
                                  rsp_ch.last_result));
            words_checked++;
         end
      end
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      grid_cfg.grid_pitch = PITCH_RESET;
      grid_cfg.enlargement = ENLARGEMENT_RESET;
      grid_cfg.max_cells_per_box = MAX_BOX_RESET;
      grid_cfg.max_total_cells = MAX_TOTAL_RESET;
      run_total = '0;
      run_status = STATUS_OK;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: pitch 128, no margin, 64 cells per box.
      queue_box('{0, 0, 127, 127, 1'b0});
      queue_box('{-1, -1, 0, 0, 1'b0});
      queue_box('{0, 0, 8192, 0, 1'b0});        // 65 cells wide
      queue_box('{0, 0, 0, 0, 1'b1});           // skipped while the failure sticks
      queue_box('{0, 0, 1023, 1151, 1'b1});     // 8 by 9 exceeds the box limit
      queue_box('{0, 0, 0, 8192, 1'b1});
      queue_box('{5, 0, 4, 0, 1'b1});
      queue_box('{0, 5, 0, 4, 1'b1});
      queue_box('{EDGE_MIN, EDGE_MIN, EDGE_MAX, EDGE_MAX, 1'b1});
      queue_box('{EDGE_MAX, EDGE_MAX, EDGE_MAX, EDGE_MAX, 1'b0});
      queue_box('{EDGE_MIN, EDGE_MIN, EDGE_MIN, EDGE_MIN, 1'b1});

      // Unit cells across the whole coordinate range overflow the index span.
      set_reg(REG_PITCH, 64'd1);
      set_reg(REG_MAX_BOX, 64'hFFFF_FFFF);
      set_reg(REG_MAX_TOTAL, 64'hFFFF_FFFF_FFFF);
      queue_box('{EDGE_MIN, 0, EDGE_MAX, 0, 1'b1});
      queue_box('{0, EDGE_MIN, 0, EDGE_MAX, 1'b1});

      set_reg(REG_ENLARGEMENT, 64'hFFFF_FFFF);
      set_reg(REG_PITCH, 64'hFFFF_FFFF);
      queue_box('{EDGE_MIN, 0, 0, 0, 1'b1});
      queue_box('{0, 0, 0, EDGE_MAX, 1'b1});
      queue_box('{EDGE_MIN + 64'hFFFF_FFFF, EDGE_MIN + 64'hFFFF_FFFF,
                  EDGE_MAX - 64'hFFFF_FFFF, EDGE_MAX - 64'hFFFF_FFFF, 1'b1});

      // Running total against a small limit, then a limit lowered mid-run.
      set_reg(REG_PITCH, 64'd128);
      set_reg(REG_ENLARGEMENT, 64'd0);
      set_reg(REG_MAX_BOX, 64'd64);
      set_reg(REG_MAX_TOTAL, 64'd10);
      queue_box('{0, 0, 255, 255, 1'b0});
      queue_box('{0, 0, 255, 255, 1'b0});
      queue_box('{0, 0, 255, 255, 1'b0});
      queue_box('{0, 0, 255, 255, 1'b1});
      set_reg(REG_MAX_TOTAL, 64'd100);
      queue_box('{0, 0, 383, 383, 1'b0});
      set_reg(REG_MAX_TOTAL, 64'd5);
      queue_box('{0, 0, 0, 0, 1'b1});

      set_reg(REG_PITCH, 64'd0);
      queue_box('{0, 0, 0, 0, 1'b1});
      set_reg(REG_PITCH, 64'd128);
      set_reg(REG_MAX_BOX, 64'd0);
      queue_box('{0, 0, 0, 0, 1'b1});
      set_reg(REG_MAX_BOX, 64'd64);
      set_reg(REG_MAX_TOTAL, 64'd0);
      queue_box('{0, 0, 0, 0, 1'b1});

      send_idle_pct = 32;
      recv_idle_pct = 81;
      wait_idle();
      pressure_req <= 1'b1;
      run_phase(128, 0, 64, 16000000, 110);
      run_phase(1, 0, 16, 300, 100);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 90);

      wait_idle();
      send_idle_pct = 81;
      recv_idle_pct = 32;
      run_phase(3, 5, 1, 40, 90);
      run_phase($urandom_range(1, 1000), $urandom_range(0, 2000), $urandom_range(1, 200),
                $urandom_range(1, 5000), 110);
      run_phase(0, 9, 64, 1000, 20);
      run_phase(100, 0, 0, 1000, 15);
      run_phase(100, 0, 64, 0, 15);

      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_phase($urandom_range(1, 32'hFFFF_FFFF), $urandom, $urandom_range(1, 32'hFFFF_FFFF),
                {16'($urandom), $urandom} | 48'd1, 110);
      run_phase(16, 3, 200, 5000, 120);
      run_phase(64, 1, 64, 16000000, 80);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && fits_expected.size() == 0)
         $display("tb_grid_membership_preflight: PASS");
      else
         $display("tb_grid_membership_preflight: FAIL");
      $finish;
   end

endmodule

@@ grid_membership_preflight.f @@
sv/gmp_pkg.sv
sv/gmp_req_if.sv
sv/gmp_rsp_if.sv
sv/gmp_csr.sv
sv/gmp_divider.sv
sv/gmp_multiplier.sv
sv/grid_membership_preflight.sv
sv/gmp_checker.sv
tb/sv/tb_grid_membership_preflight.sv
